FILE: hw/rtl/lir_pkg.sv
// Shared types and constants for the linear interpolation resampler.
`default_nettype none

package lir_pkg;

    // Position fixed point and datapath widths
    localparam int STEP_FRAC_BITS = 16;
    localparam int POS_W          = 20;
    localparam int SAMPLE_W       = 32;
    localparam int OUT_W          = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 20;

    localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1) << STEP_FRAC_BITS;
    localparam logic [POS_W-1:0] STEP_HALF = POS_W'(1) << (STEP_FRAC_BITS - 1);
    localparam logic [POS_W-1:0] STEP_RST  = POS_W'(196608);

    // Shared multiplier: signed sample times weight, or clamp magnitude times PCM full scale
    localparam int MUL_A_W = SAMPLE_W + 1;
    localparam int MUL_B_W = (STEP_FRAC_BITS + 2 > OUT_W) ? STEP_FRAC_BITS + 2 : OUT_W;
    localparam int ACC_W   = MUL_A_W + MUL_B_W;

    // Q4.28 clamp and PCM scaling
    localparam int Q_FRAC_BITS = 28;
    localparam int Q_MAG_W     = Q_FRAC_BITS + 1;
    localparam logic [Q_MAG_W-1:0] Q_ONE   = Q_MAG_W'(1) << Q_FRAC_BITS;
    localparam logic [MUL_B_W-1:0] PCM_MAX = MUL_B_W'(32767);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 1'd1;

    typedef enum logic [1:0] {
        FMT_FLOAT32 = 2'd0,
        FMT_INT16   = 2'd1,
        FMT_INT32   = 2'd2,
        FMT_NONE    = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        MAC_HOLD = 2'd0,
        MAC_LOAD = 2'd1,
        MAC_ADD  = 2'd2
    } mac_op_t;

    typedef struct packed {
        mac_op_t op;
    } mac_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_DECODE   = 3'd1,
        ST_MUL_PREV = 3'd2,
        ST_MUL_CUR  = 3'd3,
        ST_CLAMP    = 3'd4,
        ST_SCALE    = 3'd5,
        ST_EMIT     = 3'd6
    } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lir_decode.sv
// Sample decoder: float32, int16 or int32 word to signed Q4.28, else zero.
`default_nettype none

module lir_decode (
    input  wire  lir_pkg::fmt_t                 fmt,
    input  wire  logic [lir_pkg::SAMPLE_W-1:0]  word,
    output logic signed [lir_pkg::SAMPLE_W-1:0] value
);
    import lir_pkg::*;

    logic [7:0]          f_exp;
    logic [22:0]         f_frac;
    logic [23:0]         f_mant;
    logic                f_neg;
    logic [7:0]          f_rsh;
    logic [24:0]         f_rnd;
    logic [30:0]         f_mag;
    logic [SAMPLE_W-1:0] f_val;

    always_comb
    begin
        f_exp  = word[30:23];
        f_frac = word[22:0];
        f_mant = {1'b1, f_frac};
        f_neg  = word[31];
        f_rsh  = 8'd122 - f_exp;
        f_rnd  = {1'b0, f_mant} + (25'd1 << (f_rsh[4:0] - 5'd1));
        f_mag  = '0;
        f_val  = '0;
        if ((f_exp == 8'hFF && f_frac != '0) || f_exp == 8'h00)
        begin
            f_val = '0;                       // NaN and subnormals
        end
        else if (f_exp >= 8'd130)
        begin
            f_val = f_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            if (f_exp >= 8'd122)
                f_mag = 31'(f_mant) << f_exp[2:0] - 3'd2;   // e - 122, 0..7
            else if (f_rsh < 8'd26)
                f_mag = 31'(f_rnd >> f_rsh[4:0]);
            else
                f_mag = '0;
            f_val = f_neg ? -{1'b0, f_mag} : {1'b0, f_mag};
        end
    end

    always_comb
    begin
        unique case (fmt)
            FMT_FLOAT32: value = f_val;
            FMT_INT16:   value = {{3{word[15]}}, word[15:0], 13'd0};
            FMT_INT32:   value = {{3{word[31]}}, word[31:3]};
            FMT_NONE:    value = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lir_mac.sv
// Shared signed multiply-accumulate unit with registered accumulator.
`default_nettype none

module lir_mac (
    input  wire  logic                              clk,
    input  wire  lir_pkg::mac_ctrl_t                ctrl,
    input  wire  logic signed [lir_pkg::MUL_A_W-1:0] mul_a,
    input  wire  logic signed [lir_pkg::MUL_B_W-1:0] mul_b,
    output logic signed [lir_pkg::ACC_W-1:0]        acc
);
    import lir_pkg::*;

    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    always_comb
    begin
        prod = ACC_W'(mul_a) * ACC_W'(mul_b);
        case (ctrl.op)
            MAC_LOAD: acc_next = prod;
            MAC_ADD:  acc_next = acc_reg + prod;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/linear_interp_resampler.sv
// Top level of the linear interpolation sample-rate converter.
// An input is decoded, then makes 0..2 results, each by multiply previous,
//   multiply current, clamp, scale, emit: three passes through the single
//   shared multiplier. Emit waits on a stalled output; inputs wait for idle.
// Reset: async active low; format float32, step 3.0, no previous sample,
//   read position zero, output register empty.
`default_nettype none

module linear_interp_resampler (
    input  wire  logic                              clk,
    input  wire  logic                              rst_n,
    // configuration write port
    input  wire  logic                              cfg_we,
    input  wire  logic [lir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  logic [lir_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input samples
    input  wire  logic                              in_valid,
    output logic                                    in_ready,
    input  wire  logic [lir_pkg::SAMPLE_W-1:0]      sample_word,
    // resampled output
    output logic                                    out_valid,
    input  wire  logic                              out_ready,
    output logic signed [lir_pkg::OUT_W-1:0]        out_sample,
    output logic                                    last_of_run
);
    import lir_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    fmt_t             fmt_reg;
    logic [POS_W-1:0] step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg  <= FMT_FLOAT32;
            step_reg <= STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SAMPLE_FORMAT: fmt_reg  <= fmt_t'(cfg_data[1:0]);
                REG_PHASE_STEP:    step_reg <= cfg_data[POS_W-1:0];
            endcase
        end
    end

    // Steps below one half act as one half: at most two results per input
    logic [POS_W-1:0] step_eff;
    assign step_eff = (step_reg < STEP_HALF) ? STEP_HALF : step_reg;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    state_t                      state_reg, state_next;
    logic                        have_prev_reg;
    logic                        second_reg;     // second result of this run
    logic [POS_W-1:0]            pos_reg;        // read position past prev
    logic [SAMPLE_W-1:0]         word_reg;
    logic signed [SAMPLE_W-1:0]  prev_reg;
    logic signed [SAMPLE_W-1:0]  cur_reg;
    logic [Q_MAG_W-1:0]          q_mag_reg;
    logic                        q_neg_reg;
    logic                        out_valid_reg;
    logic signed [OUT_W-1:0]     out_sample_reg;
    logic                        out_last_reg;

    // ---------------------------------------------------------------
    // Decoder and shared multiplier
    // ---------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] dec_value;

    lir_decode u_decode (
        .fmt   (fmt_reg),
        .word  (word_reg),
        .value (dec_value)
    );

    mac_ctrl_t                  mac_ctrl;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]    acc;

    lir_mac u_mac (
        .clk   (clk),
        .ctrl  (mac_ctrl),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .acc   (acc)
    );

    // ---------------------------------------------------------------
    // Datapath helpers
    // ---------------------------------------------------------------
    logic [STEP_FRAC_BITS:0]   w_prev;     // 1 - f
    logic [STEP_FRAC_BITS-1:0] w_cur;      // f
    logic signed [ACC_W-1:0]   q_full;     // interpolated Q4.28, unclamped
    logic [Q_MAG_W-1:0]        q_mag;
    logic                      q_neg;
    logic [ACC_W-1:0]          pcm_rnd;
    logic [OUT_W-1:0]          pcm_mag;
    logic [POS_W:0]            pos_adv;
    logic                      more;
    logic                      emit_fire;
    logic                      in_fire;
    logic                      pos_past;   // position already at or past cur

    always_comb
    begin
        w_prev   = POS_ONE[STEP_FRAC_BITS:0] - {1'b0, pos_reg[STEP_FRAC_BITS-1:0]};
        w_cur    = pos_reg[STEP_FRAC_BITS-1:0];
        pos_past = pos_reg >= POS_ONE;

        // round to nearest, ties toward plus infinity
        q_full = (acc + (ACC_W'(1) << (STEP_FRAC_BITS - 1))) >>> STEP_FRAC_BITS;
        q_neg  = q_full[ACC_W-1];
        if (q_full > $signed(ACC_W'(Q_ONE)) || q_full < -$signed(ACC_W'(Q_ONE)))
            q_mag = Q_ONE;
        else if (q_neg)
            q_mag = Q_MAG_W'(-q_full);
        else
            q_mag = Q_MAG_W'(q_full);

        // |q| * 32767 rounded half up, sign applied afterward
        pcm_rnd = acc + (ACC_W'(1) << (Q_FRAC_BITS - 1));
        pcm_mag = pcm_rnd[Q_FRAC_BITS +: OUT_W];

        pos_adv = {1'b0, pos_reg} + {1'b0, step_eff};
        more    = !second_reg && (pos_adv < {1'b0, POS_ONE});
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_DECODE;
            ST_DECODE:
                if (have_prev_reg && !pos_past)
                    state_next = ST_MUL_PREV;
                else
                    state_next = ST_IDLE;
            ST_MUL_PREV: state_next = ST_MUL_CUR;
            ST_MUL_CUR:  state_next = ST_CLAMP;
            ST_CLAMP:    state_next = ST_SCALE;
            ST_SCALE:    state_next = ST_EMIT;
            ST_EMIT:
                if (emit_fire)
                    state_next = more ? ST_MUL_PREV : ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs (ready, emit, multiplier control, operand select)
    // ---------------------------------------------------------------
    always_comb
    begin
        in_ready    = 1'b0;
        emit_fire   = 1'b0;
        mac_ctrl.op = MAC_HOLD;
        mul_a       = MUL_A_W'(prev_reg);
        mul_b       = MUL_B_W'(w_prev);
        unique case (state_reg)
            ST_IDLE:
                in_ready = 1'b1;
            ST_MUL_PREV:
            begin
                mac_ctrl.op = MAC_LOAD;
                mul_a       = MUL_A_W'(prev_reg);
                mul_b       = MUL_B_W'(w_prev);
            end
            ST_MUL_CUR:
            begin
                mac_ctrl.op = MAC_ADD;
                mul_a       = MUL_A_W'(cur_reg);
                mul_b       = MUL_B_W'(w_cur);
            end
            ST_SCALE:
            begin
                mac_ctrl.op = MAC_LOAD;
                mul_a       = MUL_A_W'(q_mag_reg);
                mul_b       = PCM_MAX;
            end
            ST_EMIT:
                emit_fire = !out_valid_reg || out_ready;
            default:
                mac_ctrl.op = MAC_HOLD;
        endcase
    end

    assign in_fire = in_valid && in_ready;

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            have_prev_reg <= 1'b0;
            second_reg    <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_DECODE)
            begin
                have_prev_reg <= 1'b1;
                second_reg    <= 1'b0;
                // no result from this input: step the position back by one
                if (have_prev_reg && pos_past)
                    pos_reg <= pos_reg - POS_ONE;
            end

            if (emit_fire)
            begin
                second_reg <= 1'b1;
                pos_reg    <= more ? pos_adv[POS_W-1:0]
                                   : pos_adv[POS_W-1:0] - POS_ONE;
            end

            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
            word_reg <= sample_word;

        if (state_reg == ST_DECODE)
        begin
            cur_reg <= dec_value;
            // first sample, or no result: it becomes the previous sample now
            if (!have_prev_reg || pos_past)
                prev_reg <= dec_value;
        end

        if (state_reg == ST_CLAMP)
        begin
            q_mag_reg <= q_mag;
            q_neg_reg <= q_neg;
        end

        if (emit_fire)
        begin
            out_sample_reg <= q_neg_reg ? -$signed(pcm_mag) : $signed(pcm_mag);
            out_last_reg   <= !more;
            if (!more)
                prev_reg <= cur_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_sample  = out_sample_reg;
    assign last_of_run = out_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // once a previous sample exists it is never forgotten
    a_have_prev_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        have_prev_reg |=> have_prev_reg)
        else $error("previous-sample flag cleared");

    // results only come from interpolation between two samples
    a_emit_needs_prev: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |-> have_prev_reg)
        else $error("result emitted with no previous sample");

    // the second result of a run always closes the run
    a_second_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && second_reg) |=> (out_valid && last_of_run))
        else $error("third result started for one input");

    // clamped magnitude stays within plus or minus one
    a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE) |-> (q_mag_reg <= Q_ONE))
        else $error("clamp out of range");

endmodule

`default_nettype wire

FILE: tb/linear_interp_resampler_checker.sv
`timescale 1ns / 100ps
// Watches the resampler ports, predicts the PCM output stream and compares it.
module linear_interp_resampler_checker
    import lir_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [SAMPLE_W-1:0]           sample_word,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic signed [OUT_W-1:0]       out_sample,
    input  logic                          last_of_run,
    output int                            fail_count,
    output int                            pending
);

    typedef struct {
        logic signed [OUT_W-1:0] pcm;
        logic                    last;
    } pcm_result_t;

    pcm_result_t pcm_expected_q[$];

    // predictor copy of the registers and stream state
    fmt_t                       fmt_reg;
    logic [POS_W-1:0]           step_reg;
    logic signed [SAMPLE_W-1:0] held_sample;
    longint unsigned            read_pos;
    logic                       held_valid;

    function automatic logic signed [SAMPLE_W-1:0] float_to_q28(logic [31:0] w);
        int          ex;
        int          sh;
        logic [31:0] mant;
        logic [31:0] mag;
        ex   = int'(w[30:23]);
        mant = {8'd0, 1'b1, w[22:0]};
        if (ex == 255 && w[22:0] != 23'd0)
            return '0;
        if (ex == 0)
            return '0;
        if (ex >= 130)
            return w[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        if (ex >= 122) begin
            mag = mant << (ex - 122);
        end
        else begin
            sh = 122 - ex;
            if (sh >= 26)
                mag = '0;
            else
                mag = (mant + (32'd1 << (sh - 1))) >> sh;
        end
        return w[31] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] decode_word(logic [SAMPLE_W-1:0] w);
        case (fmt_reg)
            FMT_FLOAT32: return float_to_q28(w);
            FMT_INT16:   return {{3{w[15]}}, w[15:0], 13'd0};
            FMT_INT32:   return $signed(w) >>> 3;
            default:     return '0;
        endcase
    endfunction

    // Weighted blend in Q4.28, clamp to +-1, scale to PCM with half-away rounding
    function automatic logic signed [OUT_W-1:0] blend_to_pcm(
        logic signed [SAMPLE_W-1:0] a, logic signed [SAMPLE_W-1:0] b, longint unsigned frac);
        longint wa;
        longint wb;
        longint s;
        longint q;
        longint mag;
        wb = longint'(frac);
        wa = longint'(POS_ONE) - wb;
        s  = longint'(a) * wa + longint'(b) * wb;
        q  = (s + (longint'(1) <<< (STEP_FRAC_BITS - 1))) >>> STEP_FRAC_BITS;
        if (q > longint'(Q_ONE))
            q = longint'(Q_ONE);
        if (q < -longint'(Q_ONE))
            q = -longint'(Q_ONE);
        mag = (q < 0) ? -q : q;
        mag = (mag * longint'(PCM_MAX) + (longint'(1) <<< (Q_FRAC_BITS - 1))) >>> Q_FRAC_BITS;
        return (q < 0) ? OUT_W'(-mag) : OUT_W'(mag);
    endfunction

    task automatic resample_sample(input logic [SAMPLE_W-1:0] word);
        logic signed [SAMPLE_W-1:0] cur;
        longint unsigned            pos;
        longint unsigned            stp;
        longint unsigned            next_pos;
        int                         n;
        pcm_result_t                r;
        cur = decode_word(word);
        if (!held_valid) begin
            // first sample only primes the history
            held_sample = cur;
            held_valid  = 1'b1;
        end
        else begin
            stp = longint'(step_reg);
            if (stp < longint'(STEP_HALF))
                stp = longint'(STEP_HALF);
            pos = read_pos;
            n   = 0;
            while (pos < longint'(POS_ONE) && n < 2) begin
                next_pos = pos + stp;
                r.pcm  = blend_to_pcm(held_sample, cur, pos);
                r.last = (next_pos >= longint'(POS_ONE)) || (n == 1);
                pcm_expected_q.insert(pcm_expected_q.size(), r);
                pos = next_pos;
                n++;
            end
            read_pos    = pos - longint'(POS_ONE);
            held_sample = cur;
        end
    endtask

    task automatic note_failure(input string msg);
        if (fail_count < 10)
            $display("[%0t] checker: %s", $realtime, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        pcm_result_t exp_r;
        if (!rst_n) begin
            fmt_reg     = FMT_FLOAT32;
            step_reg    = STEP_RST;
            held_sample = '0;
            read_pos    = 0;
            held_valid  = 1'b0;
            pcm_expected_q.delete();
            pending     = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (pcm_expected_q.size() == 0) begin
                    note_failure($sformatf("unexpected output sample=%0d last=%0b",
                                           out_sample, last_of_run));
                end
                else begin
                    exp_r = pcm_expected_q.pop_front();
                    if (exp_r.pcm !== out_sample || exp_r.last !== last_of_run)
                        note_failure($sformatf("expected sample=%0d last=%0b, got sample=%0d last=%0b",
                                               exp_r.pcm, exp_r.last, out_sample, last_of_run));
                end
            end
            if (in_valid && in_ready)
                resample_sample(sample_word);
            if (cfg_we) begin
                case (cfg_index)
                    REG_SAMPLE_FORMAT: fmt_reg  = fmt_t'(cfg_data[1:0]);
                    REG_PHASE_STEP:    step_reg = cfg_data[POS_W-1:0];
                    default: ;
                endcase
            end
            pending = pcm_expected_q.size();
        end
    end

endmodule

FILE: tb/linear_interp_resampler_tb.sv
`timescale 1ns / 100ps
// Top of the resampler testbench: clock, reset, stimulus, pacing and verdict.
module linear_interp_resampler_tb;
    import lir_pkg::*;

    // Worst case is far below this: ~800 samples, each with a long sender gap
    // and two results waiting out long sink stalls.
    localparam int RUN_LIMIT  = 600000;
    // Cycles to let a sample that makes no PCM drain through the pipeline
    localparam int QUIET_WAIT = 16;
    localparam int RAND_BLOCKS = 15;
    localparam int BLOCK_ITEMS = 50;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [SAMPLE_W-1:0]        sample_word;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [OUT_W-1:0]    out_sample;
    logic                       last_of_run;

    int   fail_count;
    int   pending_results;
    // when set, neither side inserts idle cycles
    logic calm = 1'b0;

    linear_interp_resampler dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_word (sample_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_sample  (out_sample),
        .last_of_run (last_of_run)
    );

    linear_interp_resampler_checker resample_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_word (sample_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_sample  (out_sample),
        .last_of_run (last_of_run),
        .fail_count  (fail_count),
        .pending     (pending_results)
    );

    always #6 clk = ~clk;

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap(int idle_pct);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r >= idle_pct)
            return 0;
        if (r >= idle_pct / 6)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Raw sample word for a format: mostly plausible audio, some raw noise
    function automatic logic [SAMPLE_W-1:0] make_word(fmt_t fmt);
        int r;
        r = $urandom_range(0, 99);
        case (fmt)
            FMT_FLOAT32: begin
                if (r < 70)
                    return {1'($urandom), 8'($urandom_range(112, 128)), 23'($urandom)};
                if (r < 85)
                    return $urandom;
                case ($urandom_range(0, 5))
                    0: return 32'h7F80_0000;                     // +inf
                    1: return 32'hFF80_0000;                     // -inf
                    2: return {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};  // NaN
                    3: return {1'($urandom), 8'h00, 23'($urandom)};          // subnormal
                    4: return {1'($urandom), 8'd129, 23'($urandom)};         // from 4 to just under 8
                    default: return {1'($urandom), 8'($urandom_range(96, 121)), 23'($urandom)};
                endcase
            end
            FMT_INT16: begin
                if (r < 5)
                    return {16'($urandom), 16'h8000};
                if (r < 10)
                    return {16'($urandom), 16'h7FFF};
                return $urandom;
            end
            FMT_INT32: begin
                if (r < 5)
                    return 32'h8000_0000;
                if (r < 10)
                    return 32'h7FFF_FFFF;
                return $urandom;
            end
            default: return $urandom;
        endcase
    endfunction

    // One configuration write; only called with the block idle
    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Send one sample transaction; entered and left on a falling edge
    task automatic push_sample(input logic [SAMPLE_W-1:0] word);
        int gap;
        gap = pick_gap(45);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        sample_word <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop sending and wait until every predicted PCM sample has come out,
    // then give a zero-result sample time to leave the pipeline.
    task automatic wait_for_quiet();
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (QUIET_WAIT) @(negedge clk);
    endtask

    // Sink pacing: ready dropped for random stretches, never toggled twice per edge
    initial begin : sink_pacing
        int hold;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            hold = pick_gap(25);
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Run limit from a cycle counter
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("linear_interp_resampler_tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [31:0]      float_words [12];
        logic [31:0]      int16_words [4];
        logic [31:0]      int32_words [4];
        fmt_t             fmt;
        logic [POS_W-1:0] step;

        // Float edge cases: zeros, infinities, NaN, subnormal, unity,
        // saturation at 8, top exponent, tie rounding, underflow to zero
        float_words = '{
            32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
            32'h7FC0_0000, 32'h0000_0001, 32'h3F80_0000, 32'hBF80_0000,
            32'h4100_0000, 32'hC0FF_FFFF, 32'h3C80_0001, 32'h3000_0000
        };
        int16_words = '{
            32'h0000_8000, 32'h0000_7FFF, 32'hFFFF_0000, 32'h1234_FFFF
        };
        int32_words = '{
            32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0007, 32'hFFFF_FFF9
        };

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_SAMPLE_FORMAT;
        cfg_data    = '0;
        in_valid    = 1'b0;
        sample_word = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset settings (float32, step 3.0); the very first
        // transaction only primes the history and makes no output.
        foreach (float_words[i])
            push_sample(float_words[i]);
        wait_for_quiet();

        // int16 at the minimum legal step: up to two outputs per sample
        set_register(REG_SAMPLE_FORMAT, CFG_DATA_W'(FMT_INT16));
        set_register(REG_PHASE_STEP, CFG_DATA_W'(32768));
        foreach (int16_words[i])
            push_sample(int16_words[i]);
        wait_for_quiet();

        // int32 at step 12.0: most samples make nothing
        set_register(REG_SAMPLE_FORMAT, CFG_DATA_W'(FMT_INT32));
        set_register(REG_PHASE_STEP, CFG_DATA_W'(786432));
        foreach (int32_words[i])
            push_sample(int32_words[i]);
        wait_for_quiet();

        // Unsupported format reads zero; step under one half acts as one half
        set_register(REG_SAMPLE_FORMAT, CFG_DATA_W'(FMT_NONE));
        set_register(REG_PHASE_STEP, CFG_DATA_W'(4096));
        push_sample(32'h3F80_0000);
        push_sample(32'hDEAD_BEEF);
        wait_for_quiet();

        set_register(REG_SAMPLE_FORMAT, CFG_DATA_W'(FMT_FLOAT32));
        set_register(REG_PHASE_STEP, CFG_DATA_W'(65536));
        push_sample(32'h3F80_0000);
        push_sample(32'hBF80_0000);
        wait_for_quiet();

        // Random blocks, each with its own format and step; the stream
        // state carries over across every reconfiguration.
        for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
            fmt = fmt_t'($urandom_range(0, 7) == 0 ? FMT_NONE : $urandom_range(0, 2));
            case ($urandom_range(0, 7))
                0: step = POS_W'(32768);
                1: step = POS_W'(786432);
                2: step = POS_W'(65536);
                3: step = POS_W'(180634);        // 44.1 kHz source
                4: step = POS_W'(196608);        // 48 kHz source
                5: step = POS_W'($urandom_range(32768, 786432));
                6: step = POS_W'($urandom_range(32768, 131072));
                default: step = POS_W'($urandom_range(0, 32767));
            endcase
            set_register(REG_SAMPLE_FORMAT, CFG_DATA_W'(fmt));
            set_register(REG_PHASE_STEP, CFG_DATA_W'(step));
            calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < BLOCK_ITEMS; k++)
                push_sample(make_word(fmt));
            wait_for_quiet();
        end
        calm = 1'b0;

        if (fail_count == 0)
            $display("linear_interp_resampler_tb: PASS");
        else
            $display("linear_interp_resampler_tb: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/lir_pkg.sv
hw/rtl/lir_decode.sv
hw/rtl/lir_mac.sv
hw/rtl/linear_interp_resampler.sv
tb/linear_interp_resampler_checker.sv
tb/linear_interp_resampler_tb.sv
